// File: sv/cunrank_pkg.sv
// Shared types and constants for the combination unranking block.
`default_nettype none

package cunrank_pkg;

  localparam int MAX_N_DEF      = 32;
  localparam int ELEM_WIDTH_DEF = 32;

  // Binomials are held saturated at 2^32, which keeps every compare with a
  // 32-bit rank exact.
  localparam int              BIN_W   = 33;
  localparam logic [BIN_W-1:0] BIN_SAT = {1'b1, 32'd0};
  localparam logic [BIN_W-1:0] BIN_ONE = BIN_W'(1);

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_UNRANK = 1'b1;

  localparam logic CFG_SET_SIZE     = 1'b0;
  localparam logic CFG_CHOOSE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_TOO_MANY = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_BUILD_RD,
    S_BUILD_WR,
    S_IDLE,
    S_ERR,
    S_CHK_RD,
    S_CHK,
    S_WALK_RD,
    S_WALK
  } state_t;

endpackage

`default_nettype wire

// File: sv/cunrank_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cunrank_ram #(
  parameter int  WIDTH  = 32,
  parameter int  DEPTH  = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/combination_unrank.sv
// Top level: lexicographic unranking of r-element subsets of a stored set.
//
//  channel | direction | words                  | fields
//  in_     | slave     | set writes, requests   | tuser: func; tdata: slot, value, rank
//  out_    | master    | chosen elements        | tuser: status; tdata: element, position
//  cfg_    | slave     | register writes        | cfg_index, cfg_data
//
// After reset a Pascal table build runs, reading and then writing each table
// entry; in_tready stays low until it ends. Config writes are always taken.
// A set write goes straight to the store. A request runs its range check
// (S_CHK_RD, S_CHK), then scans set positions (S_WALK_RD, S_WALK), using the
// one shared add/subtract unit and the registered reads of the table memory.
// A result that is not taken stalls the scan until the output register frees.
`default_nettype none

module combination_unrank
  import cunrank_pkg::*;
#(
  parameter int MAX_N      = MAX_N_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // slot[4:0], value[36:5], rank[68:37], zero pad
  input  wire logic        in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // element[31:0], position[36:32], zero pad
  output logic             out_tlast,
  output logic      [1:0]  out_tuser,  // status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);

  localparam int AW     = $clog2(MAX_N + 1);
  localparam int SW     = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int PDEPTH = 2 ** (2 * AW);

  // Input fields.
  logic [4:0]  in_slot;
  logic [31:0] in_value;
  logic [31:0] in_rank;
  assign in_slot  = in_tdata[4:0];
  assign in_value = in_tdata[36:5];
  assign in_rank  = in_tdata[68:37];

  // Configuration registers.
  logic [5:0] set_size_r, choose_count_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r     <= '0;
      choose_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SET_SIZE:     set_size_r     <= cfg_data;
        CFG_CHOOSE_COUNT: choose_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  state_t           state_r, state_nxt;
  logic [AW-1:0]    bld_a_r, bld_a_nxt, bld_b_r, bld_b_nxt;
  logic [BIN_W-1:0] prev_r, prev_nxt;
  logic [AW-1:0]    n_r, n_nxt, k_r, k_nxt, pos_r, pos_nxt;
  logic [31:0]      rank_r, rank_nxt;
  status_t          err_r, err_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_elem_r, out_elem_nxt;
  logic [4:0]  out_pos_r, out_pos_nxt;
  logic        out_last_r, out_last_nxt;
  status_t     out_status_r, out_status_nxt;
  logic        out_free, out_load;

  // Memories.
  logic                  pas_we;
  logic [2*AW-1:0]       pas_waddr, pas_raddr;
  logic [BIN_W-1:0]      pas_wdata, pas_rdata;
  logic                  st_we;
  logic [ELEM_WIDTH-1:0] st_rdata;

  // Shared add/subtract unit.
  logic              alu_sub;
  logic [BIN_W-1:0]  alu_a;
  logic [BIN_W:0]    alu_res;
  logic              rank_below;
  logic [BIN_W-1:0]  bin_sum;

  logic [AW-1:0]     rem;
  logic [AW-1:0]     req_n;
  logic              take;

  assign alu_sub    = (state_r != S_BUILD_WR);
  assign alu_a      = alu_sub ? {1'b0, rank_r} : prev_r;
  assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, pas_rdata})
                              : ({1'b0, alu_a} + {1'b0, pas_rdata});
  assign rank_below = alu_res[BIN_W];
  assign bin_sum    = (alu_res > {1'b0, BIN_SAT}) ? BIN_SAT : alu_res[BIN_W-1:0];

  assign rem   = n_r - pos_r;
  assign take  = (rem == k_r) || rank_below;
  assign req_n = (int'(set_size_r) > MAX_N) ? AW'(MAX_N) : AW'(set_size_r);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign st_we     = in_tvalid && in_tready && (in_tuser == FUNC_WRITE)
                     && (int'(in_slot) < MAX_N);

  // Table read address follows the state registers, so it holds across the
  // read cycle and the cycle that uses the data.
  always_comb begin
    unique case (state_r)
      S_BUILD_RD, S_BUILD_WR: pas_raddr = {bld_a_r - AW'(1), bld_b_r};
      S_CHK_RD, S_CHK:        pas_raddr = {n_r, k_r};
      default:                pas_raddr = {rem - AW'(1), k_r - AW'(1)};
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    bld_a_nxt      = bld_a_r;
    bld_b_nxt      = bld_b_r;
    prev_nxt       = prev_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    pos_nxt        = pos_r;
    rank_nxt       = rank_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_elem_nxt   = out_elem_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_load       = 1'b0;
    pas_we         = 1'b0;
    pas_waddr      = {bld_a_r, bld_b_r};
    pas_wdata      = ((bld_b_r == '0) || (bld_b_r == bld_a_r)) ? BIN_ONE : bin_sum;

    unique case (state_r)
      S_BUILD_RD: begin
        state_nxt = S_BUILD_WR;
      end
      S_BUILD_WR: begin
        pas_we   = 1'b1;
        prev_nxt = pas_rdata;
        if (bld_b_r == bld_a_r) begin
          bld_b_nxt = '0;
          bld_a_nxt = bld_a_r + AW'(1);
          state_nxt = (bld_a_r == AW'(MAX_N)) ? S_IDLE : S_BUILD_RD;
        end else begin
          bld_b_nxt = bld_b_r + AW'(1);
          state_nxt = S_BUILD_RD;
        end
      end
      S_IDLE: begin
        if (in_tvalid && (in_tuser == FUNC_UNRANK)) begin
          rank_nxt = in_rank;
          n_nxt    = req_n;
          k_nxt    = AW'(choose_count_r);
          pos_nxt  = '0;
          if (choose_count_r == '0) begin
            err_nxt   = ST_EMPTY;
            state_nxt = S_ERR;
          end else if (int'(choose_count_r) > int'(req_n)) begin
            err_nxt   = ST_TOO_MANY;
            state_nxt = S_ERR;
          end else begin
            state_nxt = S_CHK_RD;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_valid_nxt  = 1'b1;
          out_elem_nxt   = '0;
          out_pos_nxt    = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = err_r;
          state_nxt      = S_IDLE;
        end
      end
      S_CHK_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (rank_below) begin
          state_nxt = S_WALK_RD;
        end else begin
          err_nxt   = ST_RANGE;
          state_nxt = S_ERR;
        end
      end
      S_WALK_RD: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (take) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_valid_nxt  = 1'b1;
            out_elem_nxt   = 32'(st_rdata);
            out_pos_nxt    = 5'(pos_r);
            out_last_nxt   = (k_r == AW'(1));
            out_status_nxt = ST_OK;
            k_nxt          = k_r - AW'(1);
            pos_nxt        = pos_r + AW'(1);
            state_nxt      = (k_r == AW'(1)) ? S_IDLE : S_WALK_RD;
          end
        end else begin
          rank_nxt  = alu_res[31:0];
          pos_nxt   = pos_r + AW'(1);
          state_nxt = S_WALK_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BUILD_RD;
      bld_a_r     <= '0;
      bld_b_r     <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      pos_r       <= '0;
      rank_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      bld_a_r     <= bld_a_nxt;
      bld_b_r     <= bld_b_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      pos_r       <= pos_nxt;
      rank_r      <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r       <= prev_nxt;
    err_r        <= err_nxt;
    out_elem_r   <= out_elem_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  cunrank_ram #(
    .WIDTH (BIN_W),
    .DEPTH (PDEPTH)
  ) u_pascal (
    .clk   (clk),
    .we    (pas_we),
    .waddr (pas_waddr),
    .wdata (pas_wdata),
    .raddr (pas_raddr),
    .rdata (pas_rdata)
  );

  cunrank_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (MAX_N)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (SW'(in_slot)),
    .wdata (ELEM_WIDTH'(in_value)),
    .raddr (SW'(pos_r)),
    .rdata (st_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_pos_r, out_elem_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

  // A rejected request always ends its own run.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK)) |-> out_tlast)
    else $error("error result without last flag");

  // The scan never runs out of positions before all picks are made.
  a_walk_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK_RD) |-> ((k_r != '0) && (k_r <= rem)))
    else $error("picks left exceed remaining positions");

  a_table_write: assert property (@(posedge clk) disable iff (!rst_n)
    pas_we |-> (state_r == S_BUILD_WR))
    else $error("table written outside the build");

  // A new word never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("output word overwritten");

endmodule

`default_nettype wire

// File: sim/tb_combination_unrank.sv
// Self-checking testbench for the combination unranking block.
module tb_combination_unrank;
  import cunrank_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_DEPTH      = MAX_N_DEF;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 264;

  typedef struct packed {
    logic        func;
    logic [4:0]  slot;
    logic [31:0] value;
    logic [31:0] rank;
  } cmd_t;

  typedef struct packed {
    logic [31:0] element;
    logic [4:0]  position;
    logic        last;
    status_t     status;
  } chosen_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;  // slot[4:0], value[36:5], rank[68:37], zero pad
  logic        in_tuser = 1'b0;  // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;  // element[31:0], position[36:32], zero pad
  logic        out_tlast;
  logic [1:0]  out_tuser;  // status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_data = '0;

  combination_unrank i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: binomial table, image of the stored set, register copies.
  longint unsigned binom [0:SET_DEPTH][0:SET_DEPTH];
  logic [31:0]     set_image [SET_DEPTH];
  logic [5:0]      cfg_set_size = '0;
  logic [5:0]      cfg_choose_count = '0;

  cmd_t    pending_q[$];
  chosen_t chosen_q[$];

  int unsigned items_pushed = 0;
  int unsigned items_taken = 0;
  int unsigned error_count = 0;
  int unsigned write_count = 0;
  int unsigned request_count = 0;
  int unsigned element_count = 0;
  int unsigned refusal_count = 0;
  int unsigned setting_count = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned idle_cycles = 0;

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Walks the set in order and queues the subset of the given rank, or one refusal word.
  function automatic void predict_subset(input logic [31:0] rank);
    int unsigned     n;
    int unsigned     r;
    int unsigned     picks;
    longint unsigned left;
    longint unsigned b;
    bit              take;
    chosen_t         c;
    n = (cfg_set_size > SET_DEPTH) ? SET_DEPTH : cfg_set_size;
    r = cfg_choose_count;
    c = '{element: '0, position: '0, last: 1'b1, status: ST_OK};
    if (r == 0) begin
      c.status = ST_EMPTY;
      chosen_q = {chosen_q, c};
      return;
    end
    if (r > n) begin
      c.status = ST_TOO_MANY;
      chosen_q = {chosen_q, c};
      return;
    end
    if (longint'(rank) >= binom[n][r]) begin
      c.status = ST_RANGE;
      chosen_q = {chosen_q, c};
      return;
    end
    left = rank;
    picks = r;
    for (int unsigned pos = 0; pos < n && picks > 0; pos++) begin
      take = (n - pos == picks);
      if (!take) begin
        b = binom[n - pos - 1][picks - 1];
        if (left < b) take = 1'b1;
        else left = left - b;
      end
      if (take) begin
        picks--;
        c.element  = set_image[pos];
        c.position = pos[4:0];
        c.last     = (picks == 0);
        c.status   = ST_OK;
        chosen_q = {chosen_q, c};
      end
    end
  endfunction

  // Sender: bursts of random length, some followed by a random gap.
  cmd_t        next_cmd;
  logic        in_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        next_cmd = pending_q[0];
        pending_q.delete(0);
        in_tvalid <= 1'b1;
        in_tuser  <= next_cmd.func;
        in_tdata  <= {3'b000, next_cmd.rank, next_cmd.value, next_cmd.slot};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Input side: every accepted word updates the set image or is predicted.
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      items_taken <= items_taken + 1;
      if (in_tuser == FUNC_WRITE) begin
        set_image[in_tdata[4:0]] = in_tdata[36:5];
        write_count++;
      end else begin
        predict_subset(in_tdata[68:37]);
        request_count++;
      end
    end
  end

  // Receiver: its own stall pattern, plus long hold-offs on request.
  int unsigned hold_left = 0;
  int unsigned window_left = 0;
  int unsigned rx_mode = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= LONG_HOLD;
      out_tready  <= 1'b0;
    end else begin
      if (window_left == 0) begin
        window_left <= $urandom_range(20, 80);
        rx_mode     <= $urandom_range(0, 3);
      end else begin
        window_left <= window_left - 1;
      end
      case (rx_mode)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_tready <= ($urandom_range(0, 7) != 0);
        end
      endcase
    end
  end

  // Result side: each word is held against the oldest expected word.
  chosen_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (chosen_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word element %h position %0d status %0d",
                                out_tdata[31:0], out_tdata[36:32], out_tuser));
      end else begin
        want = chosen_q[0];
        chosen_q.delete(0);
        if (want.status == ST_OK) element_count++;
        else refusal_count++;
        if (out_tdata[31:0] !== want.element)
          flag_mismatch($sformatf("element want %h got %h", want.element, out_tdata[31:0]));
        if (out_tdata[36:32] !== want.position)
          flag_mismatch($sformatf("position want %0d got %0d", want.position,
                                  out_tdata[36:32]));
        if (out_tlast !== want.last)
          flag_mismatch($sformatf("last want %b got %b", want.last, out_tlast));
        if (out_tuser !== want.status)
          flag_mismatch($sformatf("status want %0d got %0d", want.status, out_tuser));
      end
    end
  end

  // Watchdog: too long without any word moving on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired, %0d words still expected", $realtime,
               chosen_q.size());
      $display("tb_combination_unrank: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_write(input logic [4:0] slot, input logic [31:0] value);
    cmd_t c;
    c = '{func: FUNC_WRITE, slot: slot, value: value, rank: $urandom};
    pending_q = {pending_q, c};
    items_pushed++;
  endtask

  task automatic push_request(input logic [31:0] rank);
    cmd_t c;
    c = '{func: FUNC_UNRANK, slot: 5'($urandom), value: $urandom, rank: rank};
    pending_q = {pending_q, c};
    items_pushed++;
  endtask

  // Waits until every word is taken and answered, then lets the block settle.
  task automatic drain();
    while (items_taken != items_pushed || chosen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [5:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_SET_SIZE) cfg_set_size = data;
    else cfg_choose_count = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int unsigned n, input int unsigned r);
    drain();
    write_register(CFG_SET_SIZE, n[5:0]);
    write_register(CFG_CHOOSE_COUNT, r[5:0]);
    setting_count++;
  endtask

  int unsigned     random_items;
  int unsigned     phase;
  int unsigned     n_sel;
  int unsigned     r_sel;
  int unsigned     per_phase;
  int unsigned     pick;
  longint unsigned subsets;

  initial begin
    for (int a = 0; a <= SET_DEPTH; a++) begin
      for (int b = 0; b <= SET_DEPTH; b++) begin
        binom[a][b] = 0;
      end
      binom[a][0] = 1;
      for (int b = 1; b <= a; b++) begin
        binom[a][b] = binom[a - 1][b - 1] + binom[a - 1][b];
      end
    end
    foreach (set_image[i]) set_image[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: load the whole set, then the corner cases of a request.
    set_config(32, 16);
    for (int s = 0; s < SET_DEPTH; s++) begin
      push_write(s[4:0], (s == 0) ? 32'h0 : (s == SET_DEPTH - 1) ? 32'hFFFF_FFFF : $urandom);
    end
    push_request(32'd0);
    push_request(32'(binom[32][16] - 1));
    push_request(32'(binom[32][16]));
    push_request(32'hFFFF_FFFF);
    set_config(32, 32);
    push_request(32'd0);
    push_request(32'd1);
    set_config(32, 0);
    push_request($urandom);
    set_config(5, 6);
    push_request(32'd0);
    set_config(0, 0);
    push_request(32'd0);
    set_config(0, 1);
    push_request(32'd0);
    set_config(1, 1);
    push_request(32'd0);
    set_config(32, 1);
    push_request(32'd31);
    push_write(5'd31, 32'h8000_0001);
    push_request(32'd31);

    // Random part: a new register setting for each short phase.
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      n_sel = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 32 : (pick == 3) ? 31 :
              $urandom_range(2, 32);
      pick = $urandom_range(0, 9);
      if (pick == 0) r_sel = 0;
      else if (pick == 1) r_sel = (n_sel < 32) ? n_sel + 1 : $urandom_range(1, 32);
      else if (pick == 2) r_sel = n_sel;
      else r_sel = (n_sel > 0) ? $urandom_range(1, n_sel) : 0;
      if (phase == 3) begin
        n_sel = 32;
        r_sel = 16;
      end
      set_config(n_sel, r_sel);
      // Once, the receiver holds off long enough for the input to back up.
      if (phase == 3) hold_requests++;
      subsets = (r_sel <= n_sel) ? binom[n_sel][r_sel] : 0;
      per_phase = $urandom_range(16, 24);
      for (int i = 0; i < per_phase; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 4) begin
          push_write(5'($urandom), $urandom);
        end else if (pick == 4 || subsets == 0) begin
          push_request($urandom);
        end else if (pick == 5) begin
          push_request(32'(subsets));
        end else if (pick == 6) begin
          push_request(($urandom_range(0, 1) == 0) ? 32'd0 : 32'(subsets - 1));
        end else begin
          push_request($urandom_range(0, 32'(subsets - 1)));
        end
      end
      random_items += per_phase;
      phase++;
    end
    drain();

    $display("Covered %0d set writes and %0d unrank requests over %0d register settings,",
             write_count, request_count, setting_count);
    $display("with %0d chosen elements and %0d refused requests checked.",
             element_count, refusal_count);
    if (error_count == 0 && chosen_q.size() == 0) begin
      $display("tb_combination_unrank: done, clean");
    end else begin
      $display("tb_combination_unrank: done, errors");
    end
    $finish;
  end

endmodule
